// ===== hw/rtl/pbgm_pkg.sv =====
// pbgm_pkg: shared types and constants of the piecewise bilinear gaze mapper.
// Used by pbgm_axis and piecewise_bilinear_gaze_mapper; depends on nothing.

package pbgm_pkg;

   // Coefficients per patch: a, b, c, d for screen x, then for screen y
   localparam int TERMS       = 8;
   localparam int TERM_AW     = 3;
   localparam int SLOT_WIDTH  = 7;
   localparam int PATCH_WIDTH = 4;
   localparam int BOUNDS      = 3;

   localparam int TERM_X_A = 0;
   localparam int TERM_X_B = 1;
   localparam int TERM_X_C = 2;
   localparam int TERM_X_D = 3;
   localparam int TERM_Y_A = 4;
   localparam int TERM_Y_B = 5;
   localparam int TERM_Y_C = 6;
   localparam int TERM_Y_D = 7;

   // Fixed point: positions Q.4, coefficients Q.32, sum Q.40, result Q.12
   localparam int OUT_WIDTH      = 16;
   localparam int ROUND_SHIFT    = 28;
   localparam int POS_FRAC_SHIFT = 4;
   localparam int CONST_SHIFT    = 8;

   localparam logic [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
   localparam logic [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_MAP  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      CSR_GRID_MODE      = 3'd0,
      CSR_X_BOUND_FIRST  = 3'd1,
      CSR_X_BOUND_SECOND = 3'd2,
      CSR_X_BOUND_THIRD  = 3'd3,
      CSR_Y_BOUND_FIRST  = 3'd4,
      CSR_Y_BOUND_SECOND = 3'd5,
      CSR_Y_BOUND_THIRD  = 3'd6
   } csr_index_type;

   // Load enables of the arithmetic stages, one per register rank
   typedef struct packed {
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } pipe_en_type;

endpackage

// ===== hw/rtl/pbgm_axis.sv =====
// pbgm_axis: one axis of the bilinear evaluation, a*x*16 + b*y*16 + c*x*y + d*256,
// rounded to Q.12 and saturated, over four register stages. Depends on pbgm_pkg.

module pbgm_axis #(
   parameter int COEF_WIDTH = 40,
   parameter int POS_WIDTH  = 16
) (
   input  logic                                   clock,
   input  pbgm_pkg::pipe_en_type                  en,
   input  logic signed [COEF_WIDTH-1:0]           coef_a,
   input  logic signed [COEF_WIDTH-1:0]           coef_b,
   input  logic signed [COEF_WIDTH-1:0]           coef_c,
   input  logic signed [COEF_WIDTH-1:0]           coef_d,
   input  logic signed [POS_WIDTH-1:0]            pos_x,
   input  logic signed [POS_WIDTH-1:0]            pos_y,
   input  logic signed [2*POS_WIDTH-1:0]          pos_xy,
   output logic signed [pbgm_pkg::OUT_WIDTH-1:0]  result,
   output logic                                   clipped
);

   localparam int CL    = COEF_WIDTH / 2;
   localparam int CH    = COEF_WIDTH - CL;
   localparam int XY_W  = 2 * POS_WIDTH;
   localparam int SUM_W = COEF_WIDTH + XY_W + 2;
   localparam int SH_W  = SUM_W - pbgm_pkg::ROUND_SHIFT;
   localparam int OW    = pbgm_pkg::OUT_WIDTH;

   localparam logic [SUM_W-1:0] ROUND_HALF =
      {{(SUM_W-pbgm_pkg::ROUND_SHIFT){1'b0}}, 1'b1, {(pbgm_pkg::ROUND_SHIFT-1){1'b0}}};

   // Stage 3: partial products, coefficient split into a signed high half
   // and an unsigned low half
   logic signed [CL+POS_WIDTH:0]   ax_lo_in, ax_lo_ff, by_lo_in, by_lo_ff;
   logic signed [CH+POS_WIDTH-1:0] ax_hi_in, ax_hi_ff, by_hi_in, by_hi_ff;
   logic signed [CL+XY_W:0]        cxy_lo_in, cxy_lo_ff;
   logic signed [CH+XY_W-1:0]      cxy_hi_in, cxy_hi_ff;
   logic signed [COEF_WIDTH-1:0]   d_ff;

   // Stage 4: scaled terms; stage 5: sum; stage 6: rounded, clipped result
   logic signed [SUM_W-1:0] ta_in, ta_ff, tb_in, tb_ff, tc_in, tc_ff, td_in, td_ff;
   logic signed [SUM_W-1:0] sum_in, sum_ff;
   logic signed [SH_W-1:0]  shifted;
   logic [SH_W-OW:0]        upper;
   logic [OW-1:0]           res_in, res_ff;
   logic                    clip_in, clip_ff;

   assign ax_lo_in  = $signed({1'b0, coef_a[CL-1:0]}) * pos_x;
   assign ax_hi_in  = $signed(coef_a[COEF_WIDTH-1:CL]) * pos_x;
   assign by_lo_in  = $signed({1'b0, coef_b[CL-1:0]}) * pos_y;
   assign by_hi_in  = $signed(coef_b[COEF_WIDTH-1:CL]) * pos_y;
   assign cxy_lo_in = $signed({1'b0, coef_c[CL-1:0]}) * pos_xy;
   assign cxy_hi_in = $signed(coef_c[COEF_WIDTH-1:CL]) * pos_xy;

   always_ff @(posedge clock) begin
      if (en.s3) begin
         ax_lo_ff  <= ax_lo_in;
         ax_hi_ff  <= ax_hi_in;
         by_lo_ff  <= by_lo_in;
         by_hi_ff  <= by_hi_in;
         cxy_lo_ff <= cxy_lo_in;
         cxy_hi_ff <= cxy_hi_in;
         d_ff      <= coef_d;
      end
   end

   // Recombine the halves and align every term to Q.40
   assign ta_in = (SUM_W'(ax_hi_ff) <<< (CL + pbgm_pkg::POS_FRAC_SHIFT))
                + (SUM_W'(ax_lo_ff) <<< pbgm_pkg::POS_FRAC_SHIFT);
   assign tb_in = (SUM_W'(by_hi_ff) <<< (CL + pbgm_pkg::POS_FRAC_SHIFT))
                + (SUM_W'(by_lo_ff) <<< pbgm_pkg::POS_FRAC_SHIFT);
   assign tc_in = (SUM_W'(cxy_hi_ff) <<< CL) + SUM_W'(cxy_lo_ff);
   // Fold the rounding half into the constant term
   assign td_in = (SUM_W'(d_ff) <<< pbgm_pkg::CONST_SHIFT) + $signed(ROUND_HALF);

   always_ff @(posedge clock) begin
      if (en.s4) begin
         ta_ff <= ta_in;
         tb_ff <= tb_in;
         tc_ff <= tc_in;
         td_ff <= td_in;
      end
   end

   assign sum_in = ta_ff + tb_ff + tc_ff + td_ff;

   always_ff @(posedge clock) begin
      if (en.s5) begin
         sum_ff <= sum_in;
      end
   end

   // Floor to Q.12, then clip when the upper bits are not all sign copies
   assign shifted = $signed(sum_ff[SUM_W-1:pbgm_pkg::ROUND_SHIFT]);
   assign upper   = shifted[SH_W-1:OW-1];

   always_comb begin
      if ((&upper) || !(|upper)) begin
         res_in  = shifted[OW-1:0];
         clip_in = 1'b0;
      end else if (shifted[SH_W-1]) begin
         res_in  = pbgm_pkg::OUT_MIN;
         clip_in = 1'b1;
      end else begin
         res_in  = pbgm_pkg::OUT_MAX;
         clip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s6) begin
         res_ff  <= res_in;
         clip_ff <= clip_in;
      end
   end

   assign result  = $signed(res_ff);
   assign clipped = clip_ff;

endmodule

// ===== hw/rtl/piecewise_bilinear_gaze_mapper.sv =====
// piecewise_bilinear_gaze_mapper: top level, patch selection, coefficient banks and
// pipeline control. Depends on pbgm_pkg and pbgm_axis.
//
//   channel  direction  handshake              carries
//   req_     in         req_valid/req_ready    opcode, coef_slot, coef_value, raw_x, raw_y
//   rsp_     out        rsp_valid/rsp_ready    screen_x, screen_y, patch_index, saturated
//   csr_     in         csr_wen (no wait)      csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp_ready stays high; a map transaction passes six
// register ranks: input, patch select with x*y and bank read, partial products, term alignment,
// sum, round and clip. Loads write the banks as they leave rank 1 and produce no response.
// Reset clears the valid bits and the control registers; the coefficient banks keep their
// contents and must be loaded before use. rsp_ready drives a combinational ready chain: a
// rank loads whenever it is empty or its content moves on, so bubbles collapse and
// req_ready drops only when all six ranks hold transactions and rsp_ready is low.

module piecewise_bilinear_gaze_mapper #(
   parameter int MAX_PATCHES = 16,
   parameter int COEF_WIDTH  = 40,
   parameter int POS_WIDTH   = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_opcode,
   input  logic [pbgm_pkg::SLOT_WIDTH-1:0]        req_coef_slot,
   input  logic signed [COEF_WIDTH-1:0]           req_coef_value,
   input  logic signed [POS_WIDTH-1:0]            req_raw_x,
   input  logic signed [POS_WIDTH-1:0]            req_raw_y,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [pbgm_pkg::OUT_WIDTH-1:0]  rsp_screen_x,
   output logic signed [pbgm_pkg::OUT_WIDTH-1:0]  rsp_screen_y,
   output logic [pbgm_pkg::PATCH_WIDTH-1:0]       rsp_patch_index,
   output logic                                   rsp_saturated,
   // control register writes
   input  logic                                   csr_wen,
   input  logic [2:0]                             csr_index,
   input  logic [POS_WIDTH-1:0]                   csr_wdata
);

   localparam int PATCH_AW = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1;
   localparam int PW       = pbgm_pkg::PATCH_WIDTH;

   // ---------------------------------------------------------------- control registers
   logic [1:0]                  mode_ff;
   logic signed [POS_WIDTH-1:0] x_bound_ff [pbgm_pkg::BOUNDS];
   logic signed [POS_WIDTH-1:0] y_bound_ff [pbgm_pkg::BOUNDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 2'd0;
         for (int i = 0; i < pbgm_pkg::BOUNDS; i++) begin
            x_bound_ff[i] <= '0;
            y_bound_ff[i] <= '0;
         end
      end else if (csr_wen) begin
         unique case (pbgm_pkg::csr_index_type'(csr_index))
            pbgm_pkg::CSR_GRID_MODE:      mode_ff       <= csr_wdata[1:0];
            pbgm_pkg::CSR_X_BOUND_FIRST:  x_bound_ff[0] <= $signed(csr_wdata);
            pbgm_pkg::CSR_X_BOUND_SECOND: x_bound_ff[1] <= $signed(csr_wdata);
            pbgm_pkg::CSR_X_BOUND_THIRD:  x_bound_ff[2] <= $signed(csr_wdata);
            pbgm_pkg::CSR_Y_BOUND_FIRST:  y_bound_ff[0] <= $signed(csr_wdata);
            pbgm_pkg::CSR_Y_BOUND_SECOND: y_bound_ff[1] <= $signed(csr_wdata);
            pbgm_pkg::CSR_Y_BOUND_THIRD:  y_bound_ff[2] <= $signed(csr_wdata);
            default: ;  // unassigned index: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------- stage ready chain
   // Each rank loads when it is empty or its content moves on this cycle.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
   pbgm_pkg::pipe_en_type en;

   assign rdy6 = !v6_ff || rsp_ready;
   assign rdy5 = !v5_ff || rdy6;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign en.s3 = rdy3;
   assign en.s4 = rdy4;
   assign en.s5 = rdy5;
   assign en.s6 = rdy6;

   assign req_ready = rdy1;

   // ---------------------------------------------------------------- stage 1: input rank
   pbgm_pkg::op_type              op1_ff;
   logic [pbgm_pkg::SLOT_WIDTH-1:0] slot1_ff;
   logic [COEF_WIDTH-1:0]         val1_ff;
   logic signed [POS_WIDTH-1:0]   x1_ff, y1_ff;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         op1_ff   <= pbgm_pkg::op_type'(req_opcode);
         slot1_ff <= req_coef_slot;
         val1_ff  <= req_coef_value;
         x1_ff    <= req_raw_x;
         y1_ff    <= req_raw_y;
      end
   end

   // Column and row: first used boundary the position does not exceed,
   // else the number of used boundaries (grid mode).
   logic [1:0]    col_sel, row_sel;
   logic [PW-1:0] patch_sel;
   logic          patch_ok;
   logic [PATCH_AW-1:0] rd_addr;

   always_comb begin
      priority if (mode_ff >= 2'd1 && x1_ff <= x_bound_ff[0]) col_sel = 2'd0;
      else if (mode_ff >= 2'd2 && x1_ff <= x_bound_ff[1])      col_sel = 2'd1;
      else if (mode_ff == 2'd3 && x1_ff <= x_bound_ff[2])      col_sel = 2'd2;
      else                                                     col_sel = mode_ff;
   end

   always_comb begin
      priority if (mode_ff >= 2'd1 && y1_ff <= y_bound_ff[0]) row_sel = 2'd0;
      else if (mode_ff >= 2'd2 && y1_ff <= y_bound_ff[1])      row_sel = 2'd1;
      else if (mode_ff == 2'd3 && y1_ff <= y_bound_ff[2])      row_sel = 2'd2;
      else                                                     row_sel = mode_ff;
   end

   assign patch_sel = PW'(({2'b00, row_sel} * ({2'b00, mode_ff} + 4'd1)) + {2'b00, col_sel});
   assign patch_ok  = ({1'b0, patch_sel} < 5'(MAX_PATCHES));
   assign rd_addr   = patch_ok ? patch_sel[PATCH_AW-1:0] : '0;

   logic signed [2*POS_WIDTH-1:0] xy_in;
   assign xy_in = x1_ff * y1_ff;

   // Loads beyond the table are dropped; the write happens as the load leaves rank 1,
   // so a map right behind it reads the new value.
   logic [PW-1:0]                wr_patch;
   logic [PATCH_AW-1:0]          wr_addr;
   logic [pbgm_pkg::TERM_AW-1:0] wr_term;
   logic                         wr_ok, mem_we;

   assign wr_patch = slot1_ff[pbgm_pkg::SLOT_WIDTH-1:pbgm_pkg::TERM_AW];
   assign wr_term  = slot1_ff[pbgm_pkg::TERM_AW-1:0];
   assign wr_ok    = ({1'b0, wr_patch} < 5'(MAX_PATCHES));
   assign wr_addr  = wr_ok ? wr_patch[PATCH_AW-1:0] : '0;
   assign mem_we   = v1_ff && (op1_ff == pbgm_pkg::OP_LOAD) && rdy2 && wr_ok;

   // ---------------------------------------------------------------- stage 2: banks, operands
   logic [COEF_WIDTH-1:0]         coef2_ff [pbgm_pkg::TERMS];
   logic signed [COEF_WIDTH-1:0]  coef2    [pbgm_pkg::TERMS];
   logic                          ok2_ff;
   logic [PW-1:0]                 patch2_ff;
   logic signed [POS_WIDTH-1:0]   x2_ff, y2_ff;
   logic signed [2*POS_WIDTH-1:0] xy2_ff;

   for (genvar t = 0; t < pbgm_pkg::TERMS; t++) begin : g_bank
      logic [COEF_WIDTH-1:0] bank_mem [MAX_PATCHES];

      always_ff @(posedge clock) begin
         if (mem_we && wr_term == pbgm_pkg::TERM_AW'(t)) begin
            bank_mem[wr_addr] <= val1_ff;
         end
         if (rdy2) begin
            coef2_ff[t] <= bank_mem[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         ok2_ff    <= patch_ok;
         patch2_ff <= patch_sel;
         x2_ff     <= x1_ff;
         y2_ff     <= y1_ff;
         xy2_ff    <= xy_in;
      end
   end

   // A patch past the table maps with all coefficients zero
   always_comb begin
      for (int t = 0; t < pbgm_pkg::TERMS; t++) begin
         coef2[t] = ok2_ff ? $signed(coef2_ff[t]) : '0;
      end
   end

   // ---------------------------------------------------------------- valid bits, patch tag
   logic [PW-1:0] patch3_ff, patch4_ff, patch5_ff, patch6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         // loads end in rank 1
         if (rdy2) v2_ff <= v1_ff && (op1_ff == pbgm_pkg::OP_MAP);
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) patch3_ff <= patch2_ff;
      if (rdy4) patch4_ff <= patch3_ff;
      if (rdy5) patch5_ff <= patch4_ff;
      if (rdy6) patch6_ff <= patch5_ff;
   end

   // ---------------------------------------------------------------- stages 3..6: arithmetic
   logic sat_x, sat_y;

   pbgm_axis #(
      .COEF_WIDTH (COEF_WIDTH),
      .POS_WIDTH  (POS_WIDTH)
   ) u_axis_x (
      .clock   (clock),
      .en      (en),
      .coef_a  (coef2[pbgm_pkg::TERM_X_A]),
      .coef_b  (coef2[pbgm_pkg::TERM_X_B]),
      .coef_c  (coef2[pbgm_pkg::TERM_X_C]),
      .coef_d  (coef2[pbgm_pkg::TERM_X_D]),
      .pos_x   (x2_ff),
      .pos_y   (y2_ff),
      .pos_xy  (xy2_ff),
      .result  (rsp_screen_x),
      .clipped (sat_x)
   );

   pbgm_axis #(
      .COEF_WIDTH (COEF_WIDTH),
      .POS_WIDTH  (POS_WIDTH)
   ) u_axis_y (
      .clock   (clock),
      .en      (en),
      .coef_a  (coef2[pbgm_pkg::TERM_Y_A]),
      .coef_b  (coef2[pbgm_pkg::TERM_Y_B]),
      .coef_c  (coef2[pbgm_pkg::TERM_Y_C]),
      .coef_d  (coef2[pbgm_pkg::TERM_Y_D]),
      .pos_x   (x2_ff),
      .pos_y   (y2_ff),
      .pos_xy  (xy2_ff),
      .result  (rsp_screen_y),
      .clipped (sat_y)
   );

   assign rsp_valid       = v6_ff;
   assign rsp_patch_index = patch6_ff;
   assign rsp_saturated   = sat_x || sat_y;

   // ---------------------------------------------------------------- assertions
   // Only map transactions enter the arithmetic ranks
   a_map_only_enters: assert property (@(posedge clock) disable iff (reset)
      (rdy2 && !reset) |=> (v2_ff == $past(v1_ff && (op1_ff == pbgm_pkg::OP_MAP))))
      else $error("rank 2 valid does not follow the rank 1 transaction");

   // A completely full pipe with a stalled output must refuse new requests
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && v6_ff && !rsp_ready) |-> !req_ready)
      else $error("request accepted while every rank is occupied");

   // A clipped response sits on a rail of at least one axis
   a_clip_on_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_screen_x == $signed(pbgm_pkg::OUT_MAX) || rsp_screen_x == $signed(pbgm_pkg::OUT_MIN)
          || rsp_screen_y == $signed(pbgm_pkg::OUT_MAX)
          || rsp_screen_y == $signed(pbgm_pkg::OUT_MIN)))
      else $error("saturated flag set without a rail value");

endmodule
